// File: hdl/buffered_frame_sender_with_retry_top_assert.svh
// Assertion macros shared by the frame sender modules.
`ifndef BUFFERED_FRAME_SENDER_WITH_RETRY_TOP_ASSERT_SVH
`define BUFFERED_FRAME_SENDER_WITH_RETRY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BFS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// Next-cycle implication, sampled on clock, off during reset.
`define BFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// File: hdl/bfs_pkg.sv
// Types, codes and sizes shared by the buffered frame sender.
package bfs_pkg;

   // Payload buffer sizing
   localparam int BUF_DEPTH = 32;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   // Register reset values: DC1 and ACK
   localparam logic [7:0] FRAME_CONTROL_RESET = 8'h11;
   localparam logic [7:0] ACK_CODE_RESET      = 8'h06;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_CONTROL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_CODE      = 2'd1;

   // Request operation codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_SEND   = 2'd1;
   localparam logic [1:0] OP_REPLY  = 2'd2;

   typedef enum logic [2:0] {
      STS_APPENDED = 3'd0,
      STS_FULL     = 3'd1,
      STS_SENT     = 3'd2,
      STS_EMPTY    = 3'd3,
      STS_ACKED    = 3'd4,
      STS_RESENT   = 3'd5,
      STS_IGNORED  = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       last;
      status_type status;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CTRL,
      ST_LEN,
      ST_PAY,
      ST_CHECK
   } state_type;

   // Which kind of response the datapath loads
   typedef enum logic [2:0] {
      SEL_SINGLE,
      SEL_CTRL,
      SEL_LEN,
      SEL_PAY,
      SEL_CHECK
   } rsp_sel_type;

   typedef struct packed {
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      status_type  rsp_status;
      logic        append;
      logic        ack_clr;
      logic        set_await;
      logic        frame_latch;
   } ctrl_cmd_type;

   typedef struct packed {
      logic can_load;
      logic awaiting;
      logic count_full;
      logic count_zero;
      logic first_zero;
      logic ack_match;
      logic pay_last;
   } dp_status_type;

endpackage

// File: hdl/bfs_ram.sv
// Generic single-port-write, registered-read RAM.
module bfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/bfs_dp.sv
// Datapath: payload buffer, counters, check sum, config and response register.
`include "buffered_frame_sender_with_retry_top_assert.svh"
module bfs_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bfs_pkg::req_type             req_payload,
   input  logic                         csr_valid,
   input  logic [bfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output bfs_pkg::rsp_type             rsp_payload,
   input  bfs_pkg::ctrl_cmd_type        cmd,
   output bfs_pkg::dp_status_type       sts
);

   logic [7:0]                frame_control_ff, frame_control_in;
   logic [7:0]                ack_code_ff, ack_code_in;
   logic [bfs_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      await_ff, await_in;
   logic                      first_zero_ff, first_zero_in;
   bfs_pkg::status_type       frame_sts_ff, frame_sts_in;
   logic [7:0]                sum_ff, sum_in;
   logic [bfs_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bfs_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       rd_en;
   logic [bfs_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                 rd_data;
   logic                       is_len;
   logic                       is_pay;

   // Payload buffer
   bfs_ram #(
      .WIDTH (8),
      .DEPTH (bfs_pkg::BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[bfs_pkg::ADDR_W-1:0]),
      .wr_data (req_payload.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller
   always_comb begin
      sts.can_load   = !rsp_valid_ff || rsp_ready;
      sts.awaiting   = await_ff;
      sts.count_full = (count_ff == bfs_pkg::CNT_W'(bfs_pkg::BUF_DEPTH));
      sts.count_zero = (count_ff == '0);
      sts.first_zero = first_zero_ff;
      sts.ack_match  = (req_payload.data == ack_code_ff);
      sts.pay_last   = (rd_idx_ff == count_ff);
   end

   // Buffer read: the length byte fetches entry 0, each payload byte the next one
   always_comb begin
      is_len  = cmd.rsp_load && (cmd.rsp_sel == bfs_pkg::SEL_LEN);
      is_pay  = cmd.rsp_load && (cmd.rsp_sel == bfs_pkg::SEL_PAY);
      rd_en   = is_len || is_pay;
      rd_addr = is_len ? '0 : rd_idx_ff[bfs_pkg::ADDR_W-1:0];
   end

   // Config writes; unknown indexes do nothing
   always_comb begin
      frame_control_in = frame_control_ff;
      ack_code_in      = ack_code_ff;
      if (csr_valid) begin
         case (csr_index)
            bfs_pkg::CSR_FRAME_CONTROL: frame_control_in = csr_data;
            bfs_pkg::CSR_ACK_CODE:      ack_code_in      = csr_data;
            default: ;
         endcase
      end
   end

   // Buffer fill state and reply wait
   always_comb begin
      count_in      = count_ff;
      await_in      = await_ff;
      first_zero_in = first_zero_ff;
      frame_sts_in  = frame_sts_ff;
      if (cmd.append) begin
         count_in = count_ff + bfs_pkg::CNT_W'(1);
         if (count_ff == '0) begin
            first_zero_in = (req_payload.data == 8'd0);
         end
      end
      if (cmd.ack_clr) begin
         count_in = '0;
         await_in = 1'b0;
      end
      if (cmd.set_await) begin
         await_in = 1'b1;
      end
      if (cmd.frame_latch) begin
         frame_sts_in = cmd.rsp_status;
      end
   end

   // Response register, check sum and read index
   always_comb begin
      rsp_in    = rsp_ff;
      sum_in    = sum_ff;
      rd_idx_in = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_valid = 1'b1;
         rsp_in.last      = 1'b0;
         rsp_in.status    = frame_sts_ff;
         case (cmd.rsp_sel)
            bfs_pkg::SEL_SINGLE: begin
               rsp_in.out_byte  = 8'd0;
               rsp_in.out_valid = 1'b0;
               rsp_in.last      = 1'b1;
               rsp_in.status    = cmd.rsp_status;
            end
            bfs_pkg::SEL_CTRL: begin
               rsp_in.out_byte = frame_control_ff;
               sum_in          = frame_control_ff + 8'(count_ff);
            end
            bfs_pkg::SEL_LEN: begin
               rsp_in.out_byte = 8'(count_ff);
               rd_idx_in       = bfs_pkg::CNT_W'(1);
            end
            bfs_pkg::SEL_PAY: begin
               rsp_in.out_byte = rd_data;
               sum_in          = sum_ff + rd_data;
               rd_idx_in       = rd_idx_ff + bfs_pkg::CNT_W'(1);
            end
            bfs_pkg::SEL_CHECK: begin
               rsp_in.out_byte = sum_ff;
               rsp_in.last     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_control_ff <= bfs_pkg::FRAME_CONTROL_RESET;
         ack_code_ff      <= bfs_pkg::ACK_CODE_RESET;
         count_ff         <= '0;
         await_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_control_ff <= frame_control_in;
         ack_code_ff      <= ack_code_in;
         count_ff         <= count_in;
         await_ff         <= await_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      first_zero_ff <= first_zero_in;
      frame_sts_ff  <= frame_sts_in;
      sum_ff        <= sum_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `BFS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= bfs_pkg::CNT_W'(bfs_pkg::BUF_DEPTH))
   `BFS_ASSERT_SAME(a_pay_only_awaiting, is_pay, await_ff)
   `BFS_ASSERT_NEXT(a_ack_clears, cmd.ack_clr, (count_ff == '0) && !await_ff)

endmodule

// File: hdl/bfs_ctrl.sv
// Controller: request decode and frame sequencing state machine.
`include "buffered_frame_sender_with_retry_top_assert.svh"
module bfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  bfs_pkg::dp_status_type sts,
   output bfs_pkg::ctrl_cmd_type  cmd
);

   bfs_pkg::state_type  state_ff, state_in;
   logic                accept;
   bfs_pkg::status_type dec_status;
   logic                dec_append;
   logic                dec_ack;
   logic                dec_frame;

   assign accept = (state_ff == bfs_pkg::ST_IDLE) && req_valid && sts.can_load;

   // Request decode
   always_comb begin
      dec_status = bfs_pkg::STS_IGNORED;
      dec_append = 1'b0;
      dec_ack    = 1'b0;
      dec_frame  = 1'b0;
      case (req_op)
         bfs_pkg::OP_APPEND: begin
            if (sts.awaiting) begin
               dec_status = bfs_pkg::STS_IGNORED;
            end else if (sts.count_full) begin
               dec_status = bfs_pkg::STS_FULL;
            end else begin
               dec_status = bfs_pkg::STS_APPENDED;
               dec_append = 1'b1;
            end
         end
         bfs_pkg::OP_SEND: begin
            if (sts.awaiting) begin
               dec_status = bfs_pkg::STS_IGNORED;
            end else if (sts.count_zero || sts.first_zero) begin
               dec_status = bfs_pkg::STS_EMPTY;
            end else begin
               dec_status = bfs_pkg::STS_SENT;
               dec_frame  = 1'b1;
            end
         end
         bfs_pkg::OP_REPLY: begin
            if (!sts.awaiting) begin
               dec_status = bfs_pkg::STS_IGNORED;
            end else if (sts.ack_match) begin
               dec_status = bfs_pkg::STS_ACKED;
               dec_ack    = 1'b1;
            end else begin
               dec_status = bfs_pkg::STS_RESENT;
               dec_frame  = 1'b1;
            end
         end
         default: dec_status = bfs_pkg::STS_IGNORED;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfs_pkg::ST_IDLE:  if (accept && dec_frame) state_in = bfs_pkg::ST_CTRL;
         bfs_pkg::ST_CTRL:  if (sts.can_load) state_in = bfs_pkg::ST_LEN;
         bfs_pkg::ST_LEN:   if (sts.can_load) state_in = bfs_pkg::ST_PAY;
         bfs_pkg::ST_PAY:   if (sts.can_load && sts.pay_last) state_in = bfs_pkg::ST_CHECK;
         bfs_pkg::ST_CHECK: if (sts.can_load) state_in = bfs_pkg::ST_IDLE;
         default:           state_in = bfs_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.rsp_sel     = bfs_pkg::SEL_SINGLE;
      cmd.rsp_status  = dec_status;
      cmd.append      = 1'b0;
      cmd.ack_clr     = 1'b0;
      cmd.set_await   = 1'b0;
      cmd.frame_latch = 1'b0;
      case (state_ff)
         bfs_pkg::ST_IDLE: begin
            req_ready = sts.can_load;
            if (accept) begin
               if (dec_frame) begin
                  cmd.frame_latch = 1'b1;
                  cmd.set_await   = (req_op == bfs_pkg::OP_SEND);
               end else begin
                  cmd.rsp_load = 1'b1;
                  cmd.append   = dec_append;
                  cmd.ack_clr  = dec_ack;
               end
            end
         end
         bfs_pkg::ST_CTRL: begin
            cmd.rsp_load = sts.can_load;
            cmd.rsp_sel  = bfs_pkg::SEL_CTRL;
         end
         bfs_pkg::ST_LEN: begin
            cmd.rsp_load = sts.can_load;
            cmd.rsp_sel  = bfs_pkg::SEL_LEN;
         end
         bfs_pkg::ST_PAY: begin
            cmd.rsp_load = sts.can_load;
            cmd.rsp_sel  = bfs_pkg::SEL_PAY;
         end
         bfs_pkg::ST_CHECK: begin
            cmd.rsp_load = sts.can_load;
            cmd.rsp_sel  = bfs_pkg::SEL_CHECK;
         end
         default: ;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   `BFS_ASSERT_SAME(a_pay_nonempty, state_ff == bfs_pkg::ST_PAY, !sts.count_zero)
   `BFS_ASSERT_NEXT(a_check_ends, (state_ff == bfs_pkg::ST_CHECK) && sts.can_load, state_ff == bfs_pkg::ST_IDLE)

endmodule

// File: hdl/buffered_frame_sender_with_retry_top.sv
// Top level of the buffered frame sender with acknowledge and retry.
// Requests that start no frame (append, reply-acknowledge, and those answered as ignored,
// full or empty) each give one response; a send (or a non-acknowledge reply, which resends)
// gives the control byte, the length, the stored payload and an additive check byte, one per
// cycle while the response register can take them, paced by the single registered read port
// of the payload buffer and the one-entry response register.
// No new request is taken until the frame's check byte is loaded. Config writes are
// always accepted.
module buffered_frame_sender_with_retry_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bfs_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bfs_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);

   bfs_pkg::ctrl_cmd_type  cmd;
   bfs_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   bfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.op),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
